FILE: rtl/spe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types, constants and elaboration-time helpers for the positional
// encoder core.
// ----------------------------------------------------------------------------
package spe_pkg;

   localparam int unsigned MAX_MODEL_DIM = 1024;
   localparam int unsigned DIM_W         = 11;
   localparam int unsigned POS_W         = 10;
   localparam int unsigned IDX_W         = 10;
   localparam int unsigned NUM_W         = 38;
   localparam int unsigned QUO_W         = 28;
   localparam int unsigned FRAC_W        = 24;
   localparam int unsigned MANT_W        = 31;
   localparam int unsigned FREQ_W        = 25;
   localparam int unsigned ANGLE_W       = 34;
   localparam int unsigned Z_W           = 31;
   localparam int unsigned P_W           = 32;

   localparam logic [27:0] LOG2_10000_Q24 = 28'd222930821;
   localparam logic [29:0] INV_2PI_Q32    = 30'd683565276;
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd512;

   // taylor coefficients of sin(pi/2 * z), q2.30 magnitudes
   localparam logic [P_W-1:0] SIN_C0 = 32'd1686629713;
   localparam logic [P_W-1:0] SIN_C1 = 32'd693598668;
   localparam logic [P_W-1:0] SIN_C2 = 32'd85569306;
   localparam logic [P_W-1:0] SIN_C3 = 32'd5026995;
   localparam logic [P_W-1:0] SIN_C4 = 32'd172272;
   localparam logic [P_W-1:0] SIN_C5 = 32'd3864;
   localparam logic [P_W-1:0] SIN_C6 = 32'd61;

   // side data that rides along with each word
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             odd;
      logic             oor;
   } tag_type;

   function automatic logic [P_W-1:0] sin_coef(input int i);
      logic [P_W-1:0] c;
      case (i)
         0:       c = SIN_C0;
         1:       c = SIN_C1;
         2:       c = SIN_C2;
         3:       c = SIN_C3;
         4:       c = SIN_C4;
         5:       c = SIN_C5;
         default: c = SIN_C6;
      endcase
      return c;
   endfunction

   // integer square root, used at elaboration only
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // q1.30 value of 2^-(2^-j), by repeated square roots of one half
   function automatic logic [MANT_W-1:0] root_at(input int j);
      logic [63:0] root;
      root = 64'd1 << 29;
      for (int i = 1; i <= j; i++) begin
         root = isqrt64(root << 30);
      end
      return root[MANT_W-1:0];
   endfunction

endpackage

FILE: rtl/spe_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spe_divider
// Pipelined restoring divider, one quotient bit per stage, carrying the
// word's side data alongside.
// ----------------------------------------------------------------------------
module spe_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic [spe_pkg::DIM_W-1:0]    dim,
   input  logic                         in_vld,
   input  logic [spe_pkg::DIM_W-1:0]    in_rem,
   input  logic [spe_pkg::QUO_W-1:0]    in_low,
   input  spe_pkg::tag_type             in_tag,
   output logic                         out_vld,
   output logic [spe_pkg::QUO_W-1:0]    out_quo,
   output spe_pkg::tag_type             out_tag
);
   import spe_pkg::*;

   logic             vld_ff [0:QUO_W];
   logic [DIM_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] low_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   tag_type          tag_ff [0:QUO_W];

   // stage zero takes the input as is
   always_comb begin
      vld_ff[0] = in_vld;
      rem_ff[0] = in_rem;
      low_ff[0] = in_low;
      quo_ff[0] = '0;
      tag_ff[0] = in_tag;
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
      logic [DIM_W:0]   rem2;
      logic             ge;
      logic [DIM_W-1:0] rem_in;

      // shift in one numerator bit, subtract when it fits
      always_comb begin
         rem2   = {rem_ff[s-1], low_ff[s-1][QUO_W-1]};
         ge     = rem2 >= {1'b0, dim};
         rem_in = ge ? DIM_W'(rem2 - {1'b0, dim}) : DIM_W'(rem2);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= rem_in;
            low_ff[s] <= {low_ff[s-1][QUO_W-2:0], 1'b0};
            quo_ff[s] <= {quo_ff[s-1][QUO_W-2:0], ge};
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign out_vld = vld_ff[QUO_W];
   assign out_quo = quo_ff[QUO_W];
   assign out_tag = tag_ff[QUO_W];

endmodule

FILE: rtl/sinusoidal_position_encoder_core.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle; the whole pipeline moves on each cycle that
// the output register is empty or being taken.
// Depth is set by the 28-stage quotient divider and the 24 multiply stages of
// the exponent unit. Synchronous reset clears valids and sets embed_dim to 512.
// ----------------------------------------------------------------------------
// sinusoidal_position_encoder_core
// Transformer positional encoding, one q1.15 sine or cosine value per word.
// ----------------------------------------------------------------------------
module sinusoidal_position_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,   // embed_dim
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,     // position[9:0], dim_index[19:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // enc_value[15:0]
   output logic        rsp_tuser      // out_of_range
);
   import spe_pkg::*;

   logic adv;

   // embed_dim register, saturated on write
   logic [DIM_W-1:0] dim_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= (csr_wr_data > DIM_W'(MAX_MODEL_DIM)) ? DIM_W'(MAX_MODEL_DIM)
                                                         : csr_wr_data;
      end
   end

   // input stage: range check and dividend
   logic [POS_W-1:0] pos;
   logic [IDX_W-1:0] idx;
   logic [NUM_W-1:0] num;
   assign pos = req_tdata[9:0];
   assign idx = req_tdata[19:10];
   assign num = NUM_W'(NUM_W'({idx[IDX_W-1:1], 1'b0}) * NUM_W'(LOG2_10000_Q24))
              + NUM_W'(dim_ff >> 1);

   logic             s0_vld_ff;
   logic [DIM_W-1:0] s0_rem_ff;
   logic [QUO_W-1:0] s0_low_ff;
   tag_type          s0_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_rem_ff     <= DIM_W'(num[NUM_W-1:QUO_W]);
         s0_low_ff     <= num[QUO_W-1:0];
         s0_tag_ff.pos <= pos;
         s0_tag_ff.odd <= idx[0];
         s0_tag_ff.oor <= {1'b0, idx} >= dim_ff;
      end
   end

   // exponent = dividend / embed_dim
   logic             dv_vld;
   logic [QUO_W-1:0] dv_quo;
   tag_type          dv_tag;
   spe_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .dim     (dim_ff),
      .in_vld  (s0_vld_ff),
      .in_rem  (s0_rem_ff),
      .in_low  (s0_low_ff),
      .in_tag  (s0_tag_ff),
      .out_vld (dv_vld),
      .out_quo (dv_quo),
      .out_tag (dv_tag)
   );

   // 2^-frac: one root multiply per fraction bit, msb first
   logic              pw_vld_ff [0:FRAC_W];
   logic [MANT_W-1:0] pw_m_ff   [0:FRAC_W];
   logic [QUO_W-1:0]  pw_x_ff   [0:FRAC_W];
   tag_type           pw_tag_ff [0:FRAC_W];
   always_comb begin
      pw_vld_ff[0] = dv_vld;
      pw_m_ff[0]   = MANT_W'(1) << 30;
      pw_x_ff[0]   = dv_quo;
      pw_tag_ff[0] = dv_tag;
   end

   for (genvar j = 1; j <= FRAC_W; j++) begin : g_pow
      localparam logic [MANT_W-1:0] ROOT = root_at(j);
      logic [2*MANT_W-1:0] prod;
      logic [MANT_W-1:0]   m_in;
      always_comb begin
         prod = (2*MANT_W)'(pw_m_ff[j-1]) * (2*MANT_W)'(ROOT)
              + ((2*MANT_W)'(1) << 29);
         m_in = pw_x_ff[j-1][FRAC_W-j] ? MANT_W'(prod >> 30) : pw_m_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            pw_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            pw_vld_ff[j] <= pw_vld_ff[j-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            pw_m_ff[j]   <= m_in;
            pw_x_ff[j]   <= pw_x_ff[j-1];
            pw_tag_ff[j] <= pw_tag_ff[j-1];
         end
      end
   end

   // frequency: scale by integer part and round
   logic [4:0]        sh;
   logic [MANT_W:0]   m_rnd;
   assign sh    = 5'(pw_x_ff[FRAC_W][QUO_W-1:FRAC_W]) + 5'd6;
   assign m_rnd = {1'b0, pw_m_ff[FRAC_W]} + ((MANT_W+1)'(1) << (sh - 5'd1));

   logic              fq_vld_ff;
   logic [FREQ_W-1:0] fq_ff;
   tag_type           fq_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fq_vld_ff <= 1'b0;
      end else if (adv) begin
         fq_vld_ff <= pw_vld_ff[FRAC_W];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         fq_ff     <= FREQ_W'(m_rnd >> sh);
         fq_tag_ff <= pw_tag_ff[FRAC_W];
      end
   end

   // angle = position * frequency
   logic               an_vld_ff;
   logic [ANGLE_W-1:0] an_ff;
   tag_type            an_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         an_vld_ff <= 1'b0;
      end else if (adv) begin
         an_vld_ff <= fq_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         an_ff     <= ANGLE_W'(fq_tag_ff.pos) * ANGLE_W'(fq_ff);
         an_tag_ff <= fq_tag_ff;
      end
   end

   // angle times 1/(2 pi), split in two partial products
   logic        pp_vld_ff;
   logic [47:0] pp_lo_ff;
   logic [45:0] pp_hi_ff;
   tag_type     pp_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff <= 1'b0;
      end else if (adv) begin
         pp_vld_ff <= an_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_lo_ff  <= 48'(an_ff[17:0]) * 48'(INV_2PI_Q32);
         pp_hi_ff  <= 46'(an_ff[ANGLE_W-1:18]) * 46'(INV_2PI_Q32);
         pp_tag_ff <= an_tag_ff;
      end
   end

   // phase in turns, quarter turn added for cosine
   logic [64:0] turns;
   logic [23:0] phase;
   assign turns = (65'(pp_hi_ff) << 18) + 65'(pp_lo_ff);
   assign phase = turns[55:32] + (pp_tag_ff.odd ? 24'h400000 : 24'h000000);

   logic        ph_vld_ff;
   logic [23:0] ph_ff;
   tag_type     ph_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_vld_ff <= 1'b0;
      end else if (adv) begin
         ph_vld_ff <= pp_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ph_ff     <= phase;
         ph_tag_ff <= pp_tag_ff;
      end
   end

   // fold into the first quadrant
   logic [22:0] r_fold;
   assign r_fold = ph_ff[22] ? (23'h400000 - {1'b0, ph_ff[21:0]}) : {1'b0, ph_ff[21:0]};

   logic           zz_vld_ff;
   logic [Z_W-1:0] zz_ff;
   logic           zz_neg_ff;
   tag_type        zz_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         zz_vld_ff <= 1'b0;
      end else if (adv) begin
         zz_vld_ff <= ph_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         zz_ff     <= Z_W'(r_fold) << 8;
         zz_neg_ff <= ph_ff[23];
         zz_tag_ff <= ph_tag_ff;
      end
   end

   // z squared
   logic [2*Z_W-1:0] z_sq;
   assign z_sq = (2*Z_W)'(zz_ff) * (2*Z_W)'(zz_ff);

   logic           hn_vld_ff [0:6];
   logic [Z_W-1:0] hn_z_ff   [0:6];
   logic [Z_W-1:0] hn_z2_ff  [0:6];
   logic [P_W-1:0] hn_p_ff   [0:6];
   logic           hn_neg_ff [0:6];
   tag_type        hn_tag_ff [0:6];
   always_ff @(posedge clock) begin
      if (reset) begin
         hn_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         hn_vld_ff[0] <= zz_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         hn_z_ff[0]   <= zz_ff;
         hn_z2_ff[0]  <= Z_W'(z_sq >> 30);
         hn_p_ff[0]   <= SIN_C6;
         hn_neg_ff[0] <= zz_neg_ff;
         hn_tag_ff[0] <= zz_tag_ff;
      end
   end

   // horner steps, one coefficient per stage
   for (genvar h = 1; h <= 6; h++) begin : g_horner
      logic [Z_W+P_W-1:0] prod;
      assign prod = (Z_W+P_W)'(hn_z2_ff[h-1]) * (Z_W+P_W)'(hn_p_ff[h-1]);
      always_ff @(posedge clock) begin
         if (reset) begin
            hn_vld_ff[h] <= 1'b0;
         end else if (adv) begin
            hn_vld_ff[h] <= hn_vld_ff[h-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            hn_z_ff[h]   <= hn_z_ff[h-1];
            hn_z2_ff[h]  <= hn_z2_ff[h-1];
            hn_p_ff[h]   <= sin_coef(6 - h) - P_W'(prod >> 30);
            hn_neg_ff[h] <= hn_neg_ff[h-1];
            hn_tag_ff[h] <= hn_tag_ff[h-1];
         end
      end
   end

   // s = z * p
   logic [Z_W+P_W-1:0] s_prod;
   assign s_prod = (Z_W+P_W)'(hn_z_ff[6]) * (Z_W+P_W)'(hn_p_ff[6]);

   logic           sn_vld_ff;
   logic [P_W:0]   sn_ff;
   logic           sn_neg_ff;
   tag_type        sn_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sn_vld_ff <= 1'b0;
      end else if (adv) begin
         sn_vld_ff <= hn_vld_ff[6];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sn_ff     <= (P_W+1)'(s_prod >> 30);
         sn_neg_ff <= hn_neg_ff[6];
         sn_tag_ff <= hn_tag_ff[6];
      end
   end

   // round to q1.15, saturate, apply sign; out-of-range words give zero
   logic [P_W:0]  v_rnd;
   logic [15:0]   v_sat;
   logic [15:0]   enc;
   always_comb begin
      v_rnd = (sn_ff + (P_W+1)'(16384)) >> 15;
      v_sat = (v_rnd > (P_W+1)'(32767)) ? 16'd32767 : 16'(v_rnd);
      if (sn_tag_ff.oor) begin
         enc = 16'd0;
      end else if (sn_neg_ff) begin
         enc = 16'(-v_sat);
      end else begin
         enc = v_sat;
      end
   end

   // output register
   logic        out_vld_ff;
   logic [15:0] out_val_ff;
   logic        out_oor_ff;
   assign adv = ~out_vld_ff | rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= sn_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_val_ff <= enc;
         out_oor_ff <= sn_tag_ff.oor;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_oor_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the positional encoder core against a bit-exact fixed-point model of
// the sine/cosine encoding. Directed corner words come first, then random
// words under several embed_dim settings, with random stalls on both sides.
// ----------------------------------------------------------------------------

class enc_scoreboard;
   logic [15:0] exp_value[$];
   logic        exp_oor[$];
   int          n_errors;
   int          n_checked;
   logic [63:0] roots[1:24];

   function new();
      logic [63:0] r;
      r = 64'd1 << 29;
      for (int j = 1; j <= 24; j++) begin
         r = sqrt64(r << 30);
         roots[j] = r;
      end
      n_errors = 0;
      n_checked = 0;
   endfunction

   static function logic [63:0] sqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // q1.15 sine of a q0.24 phase in turns
   function logic [15:0] sine_of_phase(input logic [63:0] ph);
      logic [63:0] quad;
      logic [63:0] r;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] coef[0:6];
      coef = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
               64'd172272, 64'd3864, 64'd61};
      quad = (ph >> 22) & 64'd3;
      r = ph & 64'h3FFFFF;
      if (quad[0]) r = (64'd1 << 22) - r;
      z = r << 8;
      z2 = (z * z) >> 30;
      p = coef[6];
      for (int i = 5; i >= 0; i--) p = coef[i] - ((z2 * p) >> 30);
      s = (z * p) >> 30;
      v = (s + (64'd1 << 14)) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      return quad[1] ? -v[15:0] : v[15:0];
   endfunction

   // note one accepted request word
   function void note_request(input logic [9:0] pos, input logic [9:0] idx,
                              input logic [10:0] dim);
      logic [63:0] x;
      logic [63:0] f;
      logic [63:0] m;
      logic [63:0] freq;
      logic [63:0] ph;
      int          sh;
      if (idx >= dim) begin
         exp_value.push_back(16'd0);
         exp_oor.push_back(1'b1);
         return;
      end
      x = ({54'd0, idx[9:1], 1'b0} * 64'd222930821 + dim / 2) / dim;
      f = x & 64'hFFFFFF;
      m = 64'd1 << 30;
      for (int j = 1; j <= 24; j++) begin
         if (f[24 - j]) m = (m * roots[j] + (64'd1 << 29)) >> 30;
      end
      sh = int'((x >> 24) & 64'h1F) + 6;
      freq = (m + (64'd1 << (sh - 1))) >> sh;
      ph = (((pos * freq) * 64'd683565276) >> 32) & 64'hFFFFFF;
      if (idx[0]) ph = (ph + (64'd1 << 22)) & 64'hFFFFFF;
      exp_value.push_back(sine_of_phase(ph));
      exp_oor.push_back(1'b0);
   endfunction

   // compare one accepted response word with the oldest expectation
   function void check_response(input logic [15:0] value, input logic oor);
      logic [15:0] ev;
      logic        eo;
      n_checked++;
      if (exp_value.size() == 0) begin
         $error("unexpected rsp word: enc_value %0d out_of_range %0b",
                $signed(value), oor);
         n_errors++;
         return;
      end
      ev = exp_value.pop_front();
      eo = exp_oor.pop_front();
      if (value !== ev) begin
         $error("enc_value: expected %0d actual %0d", $signed(ev), $signed(value));
         n_errors++;
      end
      if (oor !== eo) begin
         $error("out_of_range: expected %0b actual %0b", eo, oor);
         n_errors++;
      end
   endfunction
endclass

module testbench;
   import spe_pkg::*;

   localparam int DRAIN_CYCLES = 100;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;

   enc_scoreboard enc_sb;
   logic [10:0]   cur_dim;

   sinusoidal_position_encoder_core u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // send one request word, with a random gap unless told otherwise
   task automatic send_word(input logic [9:0] pos, input logic [9:0] idx, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, idx, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      enc_sb.note_request(pos, idx, cur_dim);
      @(negedge clock);
   endtask

   // write embed_dim once the pipe has drained
   task automatic write_dim(input logic [10:0] value);
      req_tvalid <= 1'b0;
      while (enc_sb.exp_value.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_dim = (value > 11'd1024) ? 11'd1024 : value;
   endtask

   // response side: random ready with stretches held high
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) enc_sb.check_response(rsp_tdata, rsp_tuser);
   end

   // stimulus
   initial begin
      logic [10:0] dims[0:6];
      int          n_random;
      bit          gaps;
      dims = '{11'd2, 11'd1024, 11'd2047, 11'd0, 11'd3, 11'd768, 11'd1025};
      enc_sb      = new();
      cur_dim     = DIM_RESET;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed corners at reset dim
      send_word(10'd0, 10'd0, 1'b0);
      send_word(10'd0, 10'd1, 1'b0);
      send_word(10'd1023, 10'd0, 1'b0);
      send_word(10'd1023, 10'd1, 1'b0);
      send_word(10'd1023, 10'd510, 1'b1);
      send_word(10'd1023, 10'd511, 1'b1);
      send_word(10'd5, 10'd512, 1'b0);
      send_word(10'd5, 10'd1023, 1'b0);
      send_word(10'd682, 10'd2, 1'b0);
      send_word(10'd341, 10'd3, 1'b1);
      send_word(10'd512, 10'd256, 1'b1);
      send_word(10'd1, 10'd1, 1'b0);

      // random phases across several dims, including extremes
      n_random = 0;
      for (int ph = 0; ph < 7; ph++) begin
         write_dim(dims[ph]);
         send_word(10'd1023, 10'd1023, 1'b0);
         send_word(10'($urandom_range(0, 1023)),
                   (cur_dim > 11'd0) ? 10'(cur_dim - 11'd1) : 10'd0, 1'b0);
         for (int i = 0; i < 135; i++) begin
            logic [9:0] p;
            logic [9:0] x;
            gaps = (i % 40) >= 10;
            p = 10'($urandom_range(0, 1023));
            if ($urandom_range(0, 7) == 0 || cur_dim == 11'd0) begin
               x = 10'($urandom_range(0, 1023));
            end else begin
               x = 10'($urandom_range(0, cur_dim - 11'd1));
            end
            send_word(p, x, gaps);
            n_random++;
         end
      end

      // last setting leaves embed_dim at a mid value
      write_dim(11'd512);
      while (enc_sb.exp_value.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d random words over 7 embed_dim settings, %0d responses checked",
               n_random, enc_sb.n_checked);
      if (enc_sb.n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
